@@ rtl/pc1_sce_pkg.sv @@
// Shared types, constants and the control store of the PC1 encrypt unit.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package pc1_sce_pkg;

    localparam int KEY_BYTES = 16;
    localparam int KEY_HALF  = KEY_BYTES / 2;
    localparam int ROUNDS    = 8;
    localparam int ROUND_W   = $clog2(ROUNDS);

    localparam logic [15:0] MUL_A = 16'h015A;
    localparam logic [15:0] MUL_B = 16'h4E35;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;

    localparam int STEP_W = 2;
    localparam logic [STEP_W-1:0] STEP_WAIT   = 2'd0;
    localparam logic [STEP_W-1:0] STEP_LOAD   = 2'd1;
    localparam logic [STEP_W-1:0] STEP_ROUND  = 2'd2;
    localparam logic [STEP_W-1:0] STEP_FINISH = 2'd3;

    localparam logic [1:0] COND_NEVER       = 2'd0;
    localparam logic [1:0] COND_NO_INPUT    = 2'd1;
    localparam logic [1:0] COND_ROUNDS_LEFT = 2'd2;
    localparam logic [1:0] COND_OUT_BUSY    = 2'd3;

    typedef logic [7:0] pc1_byte_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic round;
        logic finish;
    } pc1_ops_t;

    typedef struct packed {
        pc1_ops_t          ops;
        logic [1:0]        cond;
        logic [STEP_W-1:0] jump_step;
        logic [STEP_W-1:0] next_step;
    } pc1_uword_t;

    typedef struct packed {
        logic in_valid;
        logic rounds_left;
        logic out_busy;
    } pc1_status_t;

    // Control store: when the condition holds the sequencer goes to jump_step,
    // otherwise to next_step.
    function automatic pc1_uword_t pc1_ucode(input logic [STEP_W-1:0] step);
        pc1_uword_t w;
        w = '0;
        unique case (step)
            STEP_WAIT: begin
                w.ops.accept = 1'b1;
                w.cond       = COND_NO_INPUT;
                w.jump_step  = STEP_WAIT;
                w.next_step  = STEP_LOAD;
            end
            STEP_LOAD: begin
                w.ops.load  = 1'b1;
                w.cond      = COND_NEVER;
                w.jump_step = STEP_LOAD;
                w.next_step = STEP_ROUND;
            end
            STEP_ROUND: begin
                w.ops.round = 1'b1;
                w.cond      = COND_ROUNDS_LEFT;
                w.jump_step = STEP_ROUND;
                w.next_step = STEP_FINISH;
            end
            STEP_FINISH: begin
                w.ops.finish = 1'b1;
                w.cond       = COND_OUT_BUSY;
                w.jump_step  = STEP_FINISH;
                w.next_step  = STEP_WAIT;
            end
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/pc1_sce_sequencer.sv @@
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on pc1_sce_pkg.
module pc1_sce_sequencer (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pc1_sce_pkg::pc1_status_t status,
    output pc1_sce_pkg::pc1_ops_t    ops
);
    import pc1_sce_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    pc1_uword_t        uword;
    logic              cond_true;

    assign uword = pc1_ucode(step_reg);
    assign ops   = uword.ops;

    always_comb begin
        unique case (uword.cond)
            COND_NEVER:       cond_true = 1'b0;
            COND_NO_INPUT:    cond_true = !status.in_valid;
            COND_ROUNDS_LEFT: cond_true = status.rounds_left;
            COND_OUT_BUSY:    cond_true = status.out_busy;
            default:          cond_true = 1'b0;
        endcase
        step_next = cond_true ? uword.jump_step : uword.next_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ rtl/pc1_sce_datapath.sv @@
// Datapath of the PC1 encrypt unit: key registers, rotating working key,
// mixing registers, one cipher round per cycle and the output register.
// Depends on pc1_sce_pkg; driven by pc1_sce_sequencer.
module pc1_sce_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pc1_sce_pkg::pc1_ops_t             ops,
    output pc1_sce_pkg::pc1_status_t          status,
    input  logic                              s_tvalid,
    input  logic [7:0]                        s_tdata,
    input  logic                              s_tuser,
    input  logic                              cfg_valid,
    input  logic [pc1_sce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                       cfg_data,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [7:0]                        m_tdata
);
    import pc1_sce_pkg::*;

    logic [63:0]        key_high_reg;
    logic [63:0]        key_low_reg;
    pc1_byte_t          key_reg [KEY_BYTES];
    logic [15:0]        mix_reg;
    logic [15:0]        sum_reg;
    logic [15:0]        chain_reg;
    logic [15:0]        acc_reg;
    logic [ROUND_W-1:0] round_reg;
    pc1_byte_t          plain_reg;
    logic               start_reg;
    logic               out_valid_reg;
    pc1_byte_t          out_data_reg;

    logic [15:0] word;
    logic [15:0] k;
    logic [15:0] idx;
    logic [31:0] prod_seed;
    logic [31:0] prod_idx;
    logic [31:0] prod_chain;
    logic [15:0] new_seed;
    logic [15:0] new_sum;
    logic [15:0] new_chain;

    // The working key rotates by two bytes per round, so the round word is
    // always taken from the first two bytes.
    assign word       = {key_reg[0], key_reg[1]};
    assign k          = chain_reg ^ word;
    assign idx        = sum_reg + {{(16-ROUND_W){1'b0}}, round_reg};
    assign prod_seed  = k * MUL_A;
    assign prod_idx   = idx * MUL_B;
    assign prod_chain = k * MUL_B;
    assign new_seed   = prod_seed[15:0];
    assign new_sum    = new_seed + prod_idx[15:0] + mix_reg;
    assign new_chain  = prod_chain[15:0] + 16'd1;

    assign status.in_valid    = s_tvalid;
    assign status.rounds_left = (round_reg != ROUND_W'(ROUNDS - 1));
    assign status.out_busy    = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_KEY_HIGH) begin
                key_high_reg <= cfg_data;
            end
            if (cfg_index == CFG_KEY_LOW) begin
                key_low_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_BYTES; i++) begin
                key_reg[i] <= '0;
            end
            mix_reg       <= '0;
            sum_reg       <= '0;
            chain_reg     <= '0;
            acc_reg       <= '0;
            round_reg     <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (ops.accept && s_tvalid) begin
                plain_reg <= s_tdata;
                start_reg <= s_tuser;
            end
            if (ops.load) begin
                chain_reg <= '0;
                acc_reg   <= '0;
                round_reg <= '0;
                if (start_reg) begin
                    for (int i = 0; i < KEY_HALF; i++) begin
                        key_reg[i]          <= key_high_reg[63-8*i -: 8];
                        key_reg[i+KEY_HALF] <= key_low_reg[63-8*i -: 8];
                    end
                    mix_reg <= '0;
                    sum_reg <= '0;
                end
            end
            if (ops.round) begin
                for (int i = 0; i < KEY_BYTES; i++) begin
                    key_reg[i] <= key_reg[(i + 2) % KEY_BYTES];
                end
                mix_reg   <= new_seed;
                sum_reg   <= new_sum;
                chain_reg <= new_chain;
                acc_reg   <= acc_reg ^ new_chain ^ new_sum;
                round_reg <= round_reg + 1'b1;
            end
            // The result is only written once the output register is free.
            if (ops.finish && !status.out_busy) begin
                for (int i = 0; i < KEY_BYTES; i++) begin
                    key_reg[i] <= key_reg[i] ^ plain_reg;
                end
                out_data_reg  <= plain_reg ^ acc_reg[15:8] ^ acc_reg[7:0];
                out_valid_reg <= 1'b1;
            end
        end
    end

endmodule

@@ rtl/pc1_stream_cipher_encrypt_unit.sv @@
// PC1 128-bit-key stream cipher, encrypt direction, one byte per item.
// After an input item is accepted the sequencer runs one key-load step, eight
// round steps and one finish step; the finish step waits while the output is stalled.
// A new item is taken only once the previous one has finished, since the eight
// dependent rounds share one round unit.
// Reset (aresetn, synchronous, active low) clears keys, working key and mixing state.
module pc1_stream_cipher_encrypt_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] plain_byte
    input  logic                              s_tuser,   // [0] start_message
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] cipher_byte
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pc1_sce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                       cfg_data
);
    import pc1_sce_pkg::*;

    pc1_ops_t    ops;
    pc1_status_t status;

    assign s_tready  = ops.accept;
    assign cfg_ready = 1'b1;

    pc1_sce_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ops     (ops)
    );

    pc1_sce_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ops       (ops),
        .status    (status),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

@@ rtl/pc1_sce_checker.sv @@
// Port-level checks for the PC1 encrypt unit, bound to the top level.
// Depends on pc1_stream_cipher_encrypt_unit.
module pc1_sce_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       cfg_ready
);

    // A waiting result keeps its value until taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // Once an item is taken the unit is busy for its ten steps of work.
    a_busy_window: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready
            ##1 !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready
            ##1 !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input taken while an item is still in work");

    // Configuration writes are never held off.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind pc1_stream_cipher_encrypt_unit pc1_sce_checker u_pc1_sce_checker (.*);

@@ dv/pc1_stream_cipher_encrypt_unit_test.sv @@
// Self-checking testbench for the PC1 stream cipher encrypt unit: keys, random messages, checks.
// Needs the package, the sequencer, the datapath and the top level from rtl/.
module pc1_stream_cipher_encrypt_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pc1_sce_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_BAD_IDX_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_IDX_HI = 2'd3;
    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned SQUEEZE_AT = 300;
    localparam int unsigned SQUEEZE_LEN = 400;

    typedef struct {
        logic      start;
        pc1_byte_t plain;
    } msg_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [7:0]      s_tdata = '0;
    logic            s_tuser = 1'b0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [7:0]      m_tdata;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]     cfg_data = '0;

    pc1_stream_cipher_encrypt_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the block's keys and cipher state.
    logic [63:0] key_hi_mirror = '0;
    logic [63:0] key_lo_mirror = '0;
    pc1_byte_t   wkey_mirror [KEY_BYTES];
    logic [15:0] seed_mirror = '0;
    logic [15:0] rsum_mirror = '0;

    msg_item_t   plain_backlog [$];
    pc1_byte_t   cipher_due [$];
    int unsigned mismatches = 0;
    int unsigned ciphers_seen = 0;
    bit          idle_on = 1'b1;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        if (roll < 97)
            return $urandom_range(5, 12);
        return $urandom_range(20, 60);
    endfunction

    // Encrypts one byte on the mirrored state and returns the cipher byte.
    function automatic pc1_byte_t encipher(input logic start, input pc1_byte_t plain);
        logic [15:0] chain, acc, word, k, idx, seed_next, sum, prod;
        int r;
        if (start) begin
            for (r = 0; r < KEY_HALF; r++) begin
                wkey_mirror[r]            = key_hi_mirror[63 - 8 * r -: 8];
                wkey_mirror[r + KEY_HALF] = key_lo_mirror[63 - 8 * r -: 8];
            end
            seed_mirror = '0;
            rsum_mirror = '0;
        end
        chain = '0;
        acc   = '0;
        // All products and sums are kept to 16 bits by the width of the targets.
        for (r = 0; r < ROUNDS; r++) begin
            word      = {wkey_mirror[2 * r], wkey_mirror[2 * r + 1]};
            k         = chain ^ word;
            idx       = rsum_mirror + 16'(r);
            seed_next = k * MUL_A;
            sum       = seed_next + idx * MUL_B + seed_mirror;
            prod      = k * MUL_B + 16'd1;
            seed_mirror = seed_next;
            rsum_mirror = sum;
            chain       = prod;
            acc         = acc ^ prod ^ sum;
        end
        for (r = 0; r < KEY_BYTES; r++)
            wkey_mirror[r] = wkey_mirror[r] ^ plain;
        return plain ^ acc[15:8] ^ acc[7:0];
    endfunction

    // Driver: offers queued items, predicting each one as it is accepted.
    int unsigned send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                cipher_due.push_back(encipher(s_tuser, s_tdata));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (plain_backlog.size() > 0) begin
                    msg_item_t item;
                    item = plain_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= item.start;
                    s_tdata  <= item.plain;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every accepted cipher byte and throttles m_tready.
    int unsigned stall_left = 0;
    bit          squeezed = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                ciphers_seen++;
                if (cipher_due.size() == 0) begin
                    mismatches++;
                    $error("cipher_byte: none expected, actual 0x%02h", m_tdata);
                end else begin
                    pc1_byte_t want;
                    want = cipher_due.pop_front();
                    if (m_tdata !== want) begin
                        mismatches++;
                        $error("cipher_byte: expected 0x%02h, actual 0x%02h", want, m_tdata);
                    end
                end
            end
            // One long hold-off so that the block backs up into its input.
            if (!squeezed && ciphers_seen >= SQUEEZE_AT) begin
                squeezed = 1'b1;
                stall_left = SQUEEZE_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = pick_gap();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    int unsigned quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else if (aresetn)
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == CFG_KEY_HIGH)
            key_hi_mirror = val;
        else if (idx == CFG_KEY_LOW)
            key_lo_mirror = val;
    endtask

    task automatic queue_byte(input logic start, input pc1_byte_t plain);
        msg_item_t item;
        item.start = start;
        item.plain = plain;
        plain_backlog.push_back(item);
    endtask

    task automatic drain();
        while (plain_backlog.size() > 0 || s_tvalid || cipher_due.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    initial begin
        int phase;
        int n;
        int count;
        pc1_byte_t plain;
        for (n = 0; n < KEY_BYTES; n++)
            wkey_mirror[n] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Bytes before any start run on the all-zero reset key.
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'hFF);
        queue_byte(1'b0, 8'h5A);
        queue_byte(1'b1, 8'hA5);
        drain();

        // Writes to unused indexes must leave both key halves alone.
        write_reg(CFG_KEY_HIGH, '1);
        write_reg(CFG_KEY_LOW, '0);
        write_reg(CFG_BAD_IDX_LO, {$urandom(), $urandom()});
        write_reg(CFG_BAD_IDX_HI, {$urandom(), $urandom()});
        queue_byte(1'b1, 8'h00);
        queue_byte(1'b0, 8'hFF);
        queue_byte(1'b0, 8'h80);
        queue_byte(1'b0, 8'h01);
        drain();

        // A new key only counts from the next start, not for the message in flight.
        write_reg(CFG_KEY_HIGH, '0);
        write_reg(CFG_KEY_LOW, '1);
        queue_byte(1'b0, 8'h33);
        queue_byte(1'b1, 8'h7E);
        queue_byte(1'b0, 8'h00);
        drain();

        write_reg(CFG_KEY_HIGH, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_KEY_LOW, 64'hFEDC_BA98_7654_3210);
        queue_byte(1'b1, 8'hFF);
        queue_byte(1'b0, 8'hFF);
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b1, 8'h00);
        queue_byte(1'b1, 8'hC3);
        queue_byte(1'b0, 8'h3C);
        drain();

        // Random messages, each phase under fresh keys; some phases run without idling.
        for (phase = 0; phase < 8; phase++) begin
            idle_on = (phase % 3) != 1;
            write_reg(CFG_KEY_HIGH, pick_key());
            write_reg(CFG_KEY_LOW, pick_key());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_BAD_IDX_HI : CFG_BAD_IDX_LO,
                          {$urandom(), $urandom()});
            count = $urandom_range(120, 140);
            for (n = 0; n < count; n++) begin
                case ($urandom_range(0, 9))
                    0:       plain = 8'h00;
                    1:       plain = 8'hFF;
                    default: plain = 8'($urandom_range(0, 255));
                endcase
                if (n == 0)
                    queue_byte($urandom_range(0, 3) != 0, plain);
                else
                    queue_byte($urandom_range(0, 11) == 0, plain);
            end
            drain();
        end

        if (mismatches == 0 && cipher_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pc1_sce_pkg.sv
rtl/pc1_sce_sequencer.sv
rtl/pc1_sce_datapath.sv
rtl/pc1_stream_cipher_encrypt_unit.sv
rtl/pc1_sce_checker.sv
dv/pc1_stream_cipher_encrypt_unit_test.sv
